@@ rtl/bmds_pkg.sv @@
// Shared constants and types for the bit clock divider solver.
`default_nettype none
package bmds_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned CNT_W       = $clog2(DATA_W + 1);
    localparam int unsigned NUM_PORTS   = 8;
    localparam int unsigned PORT_W      = 3;
    localparam int unsigned NUM_SOURCES = 4;
    localparam int unsigned MN_W        = 24;

    localparam logic [DATA_W-1:0] SCR_LIMIT = 32'd4096;
    localparam logic [DATA_W-1:0] MN_MAX    = 32'h00ffffff;

    // port source codes
    localparam logic [1:0] SRC_NONE    = 2'd0;
    localparam logic [1:0] SRC_MN      = 2'd1;
    localparam logic [1:0] SRC_CRYSTAL = 2'd2;

    // input commands
    localparam logic CMD_SET     = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_FREQ_0   = 3'd0;
    localparam logic [2:0] REG_FREQ_1   = 3'd1;
    localparam logic [2:0] REG_FREQ_2   = 3'd2;
    localparam logic [2:0] REG_FREQ_3   = 3'd3;
    localparam logic [2:0] REG_COUNT    = 3'd4;
    localparam logic [2:0] REG_CRYSTAL  = 3'd5;

    typedef logic [DATA_W-1:0] word_t;

endpackage
`default_nettype wire

@@ rtl/bclk_mn_divider_solver.sv @@
// Top level of the bit clock divider solver: sequencer, port state and result register.
// One item per transfer; the result comes back as one transfer on the m_ side and the
// next item is taken once that result has been taken. A release or a zero rate ends
// straight from idle. A set runs every division and remainder through one bit-serial
// divider: up to 4 entry checks for the crystal path, up to 4 exact checks, then per
// entry one quotient, up to SCR_LIMIT/2 trial remainders, a gcd of up to about 47
// remainder steps and two more divisions. The worst case is four entries each running
// the full downward SCR search.
`default_nettype none
module bclk_mn_divider_solver (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_wr_en,
    input  wire  [2:0]                   cfg_index,
    input  wire  bmds_pkg::word_t        cfg_data,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [39:0]                  s_tdata,   // port[2:0], bit_rate[34:3], zero pad
    input  wire                          s_tuser,   // cmd
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [87:0]                  m_tdata    // status, source_kind, need_ecs,
                                                    // scr_divisor, m_value, n_value,
                                                    // new_source_selected,
                                                    // shared_source_entry, zero pad
);
    import bmds_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_CX   = 9'b000000010,
        ST_FX   = 9'b000000100,
        ST_SM0  = 9'b000001000,
        ST_SMOD = 9'b000010000,
        ST_GCD  = 9'b000100000,
        ST_NDIV = 9'b001000000,
        ST_MDIV = 9'b010000000,
        ST_SPARE = 9'b100000000
    } state_t;

    // configuration
    word_t      freq_reg [NUM_SOURCES];
    logic [2:0] count_reg;
    logic [2:0] crystal_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg[0] <= 32'd19200000;
            freq_reg[1] <= 32'd24576000;
            freq_reg[2] <= 32'd96000000;
            freq_reg[3] <= 32'd0;
            count_reg   <= 3'd3;
            crystal_reg <= 3'd4;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FREQ_0:  freq_reg[0] <= cfg_data;
                REG_FREQ_1:  freq_reg[1] <= cfg_data;
                REG_FREQ_2:  freq_reg[2] <= cfg_data;
                REG_FREQ_3:  freq_reg[3] <= cfg_data;
                REG_COUNT:   count_reg   <= cfg_data[2:0];
                REG_CRYSTAL: crystal_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    state_t            state_reg, state_next;
    logic              wait_reg, wait_next;
    logic [2:0]        idx_reg, idx_next;
    logic              locked_reg, locked_next;
    logic              in_use_reg, in_use_next;
    logic [PORT_W-1:0] port_reg, port_next;
    word_t             bclk_reg, bclk_next;
    word_t             s_reg, s_next;
    word_t             part_reg, part_next;
    word_t             ga_reg, ga_next;
    word_t             gb_reg, gb_next;
    logic [MN_W-1:0]   nn_reg, nn_next;
    logic [1:0]        src_reg [NUM_PORTS];
    logic [1:0]        src_next [NUM_PORTS];
    logic [1:0]        mn_entry_reg, mn_entry_next;
    logic              mn_written_reg, mn_written_next;

    logic              ov_reg, ov_next;
    logic              o_status_reg, o_status_next;
    logic [1:0]        o_kind_reg, o_kind_next;
    logic              o_ecs_reg, o_ecs_next;
    word_t             o_scr_reg, o_scr_next;
    logic [MN_W-1:0]   o_m_reg, o_m_next;
    logic [MN_W-1:0]   o_n_reg, o_n_next;
    logic              o_fresh_reg, o_fresh_next;
    logic [1:0]        o_shared_reg, o_shared_next;

    logic              div_start, div_done;
    word_t             div_a, div_b, div_q, div_r;

    bmds_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    logic [2:0]        used_cnt;
    word_t             freq_sel;
    logic              in_use_acc;
    logic              fin;
    logic              f_status;
    logic [1:0]        f_kind;
    word_t             f_scr;
    logic [MN_W-1:0]   f_m, f_n;
    logic              f_fresh;
    logic              sm_fail;
    logic              sm_ok;
    word_t             s_odd;

    assign used_cnt = (count_reg > 3'(NUM_SOURCES)) ? 3'(NUM_SOURCES) : count_reg;
    assign freq_sel = freq_reg[idx_reg[1:0]];
    assign s_tready = (state_reg == ST_IDLE) && !ov_reg;

    // another port already on the M/N path locks the shared source
    always_comb begin
        in_use_acc = 1'b0;
        for (int i = 0; i < NUM_PORTS; i++)
            if (PORT_W'(i) != s_tdata[2:0] && src_reg[i] == SRC_MN)
                in_use_acc = 1'b1;
    end

    always_comb begin
        state_next      = state_reg;
        wait_next       = wait_reg;
        idx_next        = idx_reg;
        locked_next     = locked_reg;
        in_use_next     = in_use_reg;
        port_next       = port_reg;
        bclk_next       = bclk_reg;
        s_next          = s_reg;
        part_next       = part_reg;
        ga_next         = ga_reg;
        gb_next         = gb_reg;
        nn_next         = nn_reg;
        src_next        = src_reg;
        mn_entry_next   = mn_entry_reg;
        mn_written_next = mn_written_reg;
        ov_next         = ov_reg && !m_tready;
        o_status_next   = o_status_reg;
        o_kind_next     = o_kind_reg;
        o_ecs_next      = o_ecs_reg;
        o_scr_next      = o_scr_reg;
        o_m_next        = o_m_reg;
        o_n_next        = o_n_reg;
        o_fresh_next    = o_fresh_reg;
        o_shared_next   = o_shared_reg;
        div_start       = 1'b0;
        div_a           = freq_sel;
        div_b           = bclk_reg;
        fin             = 1'b0;
        f_status        = 1'b1;
        f_kind          = SRC_NONE;
        f_scr           = '0;
        f_m             = '0;
        f_n             = '0;
        f_fresh         = 1'b0;
        sm_fail         = 1'b0;
        sm_ok           = 1'b0;
        s_odd           = div_q[0] ? (div_q - 1'b1) : div_q;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    port_next            = s_tdata[2:0];
                    bclk_next            = s_tdata[34:3];
                    in_use_next          = in_use_acc;
                    src_next[s_tdata[2:0]] = SRC_NONE;
                    wait_next            = 1'b0;
                    idx_next             = '0;
                    if (s_tuser == CMD_RELEASE) begin
                        fin      = 1'b1;
                        f_status = 1'b0;
                    end else if (s_tdata[34:3] == '0) begin
                        fin = 1'b1;
                    end else begin
                        state_next = ST_CX;
                    end
                end
            end

            ST_CX: begin
                if (idx_reg >= used_cnt) begin
                    if (in_use_reg) begin
                        idx_next    = {1'b0, mn_entry_reg};
                        locked_next = 1'b1;
                        state_next  = ST_SM0;
                    end else begin
                        idx_next    = '0;
                        locked_next = 1'b0;
                        state_next  = ST_FX;
                    end
                end else if (freq_sel == '0) begin
                    idx_next = idx_reg + 1'b1;
                end else if (!wait_reg) begin
                    div_start = 1'b1;
                    wait_next = 1'b1;
                end else if (div_done) begin
                    wait_next = 1'b0;
                    idx_next  = idx_reg + 1'b1;
                    if (div_r == '0) begin
                        if (idx_reg == crystal_reg) begin
                            fin      = 1'b1;
                            f_status = 1'b0;
                            f_kind   = SRC_CRYSTAL;
                            f_scr    = div_q;
                            f_m      = MN_W'(1);
                            f_n      = MN_W'(1);
                            src_next[port_reg] = SRC_CRYSTAL;
                        end else if (!in_use_reg ||
                                     (mn_written_reg && {1'b0, mn_entry_reg} == idx_reg)) begin
                            idx_next = used_cnt;   // leave the search
                        end
                    end
                end
            end

            ST_FX: begin
                if (idx_reg >= used_cnt) begin
                    idx_next    = '0;
                    locked_next = 1'b0;
                    state_next  = ST_SM0;
                end else if (freq_sel == '0) begin
                    idx_next = idx_reg + 1'b1;
                end else if (!wait_reg) begin
                    div_start = 1'b1;
                    wait_next = 1'b1;
                end else if (div_done) begin
                    wait_next = 1'b0;
                    idx_next  = idx_reg + 1'b1;
                    if (div_r == '0) begin
                        locked_next = 1'b0;
                        s_next      = div_q;
                        ga_next     = 32'd1;
                        nn_next     = MN_W'(1);
                        sm_ok       = 1'b1;
                    end
                end
            end

            ST_SM0: begin
                if (!locked_reg && idx_reg >= used_cnt) begin
                    fin = 1'b1;
                end else if (freq_sel == '0) begin
                    sm_fail = 1'b1;
                end else if (!wait_reg) begin
                    div_start = 1'b1;
                    wait_next = 1'b1;
                end else if (div_done) begin
                    wait_next = 1'b0;
                    if (div_r == '0 && div_q < SCR_LIMIT) begin
                        s_next  = div_q;
                        ga_next = 32'd1;
                        nn_next = MN_W'(1);
                        sm_ok   = 1'b1;
                    end else if ({bclk_reg, 1'b0} >= {1'b0, freq_sel}) begin
                        sm_fail = 1'b1;
                    end else begin
                        s_next     = (s_odd > SCR_LIMIT) ? SCR_LIMIT : s_odd;
                        state_next = ST_SMOD;
                    end
                end
            end

            ST_SMOD: begin
                div_b = s_reg;
                if (!wait_reg) begin
                    div_start = 1'b1;
                    wait_next = 1'b1;
                end else if (div_done) begin
                    wait_next = 1'b0;
                    if (div_r == '0) begin
                        part_next  = div_q;
                        ga_next    = bclk_reg;
                        gb_next    = div_q;
                        state_next = ST_GCD;
                    end else if (s_reg == 32'd2) begin
                        sm_fail = 1'b1;
                    end else begin
                        s_next = s_reg - 32'd2;
                    end
                end
            end

            ST_GCD: begin
                div_a = ga_reg;
                div_b = gb_reg;
                if (gb_reg == '0) begin
                    state_next = ST_NDIV;
                end else if (!wait_reg) begin
                    div_start = 1'b1;
                    wait_next = 1'b1;
                end else if (div_done) begin
                    wait_next = 1'b0;
                    ga_next   = gb_reg;
                    gb_next   = div_r;
                end
            end

            ST_NDIV: begin
                div_a = part_reg;
                div_b = ga_reg;
                if (!wait_reg) begin
                    div_start = 1'b1;
                    wait_next = 1'b1;
                end else if (div_done) begin
                    wait_next = 1'b0;
                    if (div_q > MN_MAX) begin
                        sm_fail = 1'b1;
                    end else begin
                        nn_next    = div_q[MN_W-1:0];
                        state_next = ST_MDIV;
                    end
                end
            end

            ST_MDIV: begin
                div_a = bclk_reg;
                div_b = ga_reg;
                if (!wait_reg) begin
                    div_start = 1'b1;
                    wait_next = 1'b1;
                end else if (div_done) begin
                    wait_next = 1'b0;
                    ga_next   = {8'd0, div_q[MN_W-1:0]};
                    sm_ok     = 1'b1;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (sm_fail) begin
            if (locked_reg) begin
                fin = 1'b1;
            end else begin
                idx_next   = idx_reg + 1'b1;
                state_next = ST_SM0;
            end
        end

        if (sm_ok) begin
            fin      = 1'b1;
            f_status = 1'b0;
            f_kind   = SRC_MN;
            f_scr    = s_next;
            f_m      = ga_next[MN_W-1:0];
            f_n      = nn_next;
            src_next[port_reg] = SRC_MN;
            if (!locked_reg) begin
                mn_entry_next   = idx_reg[1:0];
                mn_written_next = 1'b1;
                f_fresh         = 1'b1;
            end
        end

        if (fin) begin
            state_next    = ST_IDLE;
            wait_next     = 1'b0;
            ov_next       = 1'b1;
            o_status_next = f_status;
            o_kind_next   = f_kind;
            o_ecs_next    = (f_kind == SRC_MN);
            o_scr_next    = f_scr;
            o_m_next      = f_m;
            o_n_next      = f_n;
            o_fresh_next  = f_fresh;
            o_shared_next = mn_written_next ? mn_entry_next : 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            wait_reg       <= 1'b0;
            ov_reg         <= 1'b0;
            mn_written_reg <= 1'b0;
            for (int i = 0; i < NUM_PORTS; i++)
                src_reg[i] <= SRC_NONE;
        end else begin
            state_reg      <= state_next;
            wait_reg       <= wait_next;
            ov_reg         <= ov_next;
            mn_written_reg <= mn_written_next;
            src_reg        <= src_next;
        end
        idx_reg      <= idx_next;
        locked_reg   <= locked_next;
        in_use_reg   <= in_use_next;
        port_reg     <= port_next;
        bclk_reg     <= bclk_next;
        s_reg        <= s_next;
        part_reg     <= part_next;
        ga_reg       <= ga_next;
        gb_reg       <= gb_next;
        nn_reg       <= nn_next;
        mn_entry_reg <= mn_entry_next;
        o_status_reg <= o_status_next;
        o_kind_reg   <= o_kind_next;
        o_ecs_reg    <= o_ecs_next;
        o_scr_reg    <= o_scr_next;
        o_m_reg      <= o_m_next;
        o_n_reg      <= o_n_next;
        o_fresh_reg  <= o_fresh_next;
        o_shared_reg <= o_shared_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {1'b0, o_shared_reg, o_fresh_reg, o_n_reg, o_m_reg, o_scr_reg,
                       o_ecs_reg, o_kind_reg, o_status_reg};

endmodule
`default_nettype wire

@@ rtl/bmds_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module bmds_div (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    start,
    input  wire  bmds_pkg::word_t  dividend,
    input  wire  bmds_pkg::word_t  divisor,
    output logic                   done,
    output bmds_pkg::word_t        quotient,
    output bmds_pkg::word_t        remainder
);
    import bmds_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    word_t             quo_reg, quo_next;
    word_t             rem_reg, rem_next;
    word_t             dvs_reg, dvs_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DATA_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (!diff[DATA_W]) begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

@@ sim/tb_bclk_mn_divider_solver.sv @@
// Testbench for the bit clock divider solver: directed table, random phases, scoreboard.
`timescale 1ns / 100ps

module tb_bclk_mn_divider_solver;
    import bmds_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 100000000;
    localparam int unsigned HOLD_CYCLES = 400;

    // lowest bit last, matching the m_tdata layout
    typedef struct packed {
        logic [1:0]  shared;
        logic        fresh;
        logic [23:0] n;
        logic [23:0] m;
        logic [31:0] scr;
        logic        ecs;
        logic [1:0]  kind;
        logic        status;
    } solve_t;

    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        word_t       val;
        logic        cmd;
        logic [2:0]  port;
        logic [31:0] rate;
        bit          typed;
        solve_t      want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    word_t       cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // port[2:0], bit_rate[34:3], zero pad
    logic        s_tuser = 1'b0; // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [87:0] m_tdata;        // status, source_kind, need_ecs, scr_divisor, m_value,
                                 // n_value, new_source_selected, shared_source_entry

    bclk_mn_divider_solver i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // predictor state
    logic [31:0] freq_tbl [4];
    logic [2:0]  entry_count;
    logic [2:0]  crystal_sel;
    logic [1:0]  port_src [NUM_PORTS];
    logic [1:0]  mn_entry;
    bit          mn_valid;

    solve_t      pending_q [$];
    int unsigned err_cnt = 0;
    int unsigned cycle_cnt = 0;
    bit          quiet = 0;
    bit          hold_req = 0;
    row_t        rows [$];

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] gcd_of(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic int unsigned entries_used();
        return (entry_count > NUM_SOURCES) ? NUM_SOURCES : entry_count;
    endfunction

    function automatic bit solve_mn_div(input logic [31:0] f, input logic [31:0] b,
                                        output logic [31:0] scr, output logic [31:0] m,
                                        output logic [31:0] n);
        logic [31:0] s, part, g, nn;
        scr = 0; m = 0; n = 0;
        if (f == 0) return 0;
        s = f / b;
        if (f % b == 0 && s < SCR_LIMIT) begin
            scr = s; m = 1; n = 1;
            return 1;
        end
        if ({b, 1'b0} >= {1'b0, f}) return 0;
        if (s > 1 && s[0]) s = s - 1;
        if (s > SCR_LIMIT) s = SCR_LIMIT;
        while (s > 1 && f % s != 0) s = s - 2;
        if (s == 0) return 0;
        part = f / s;
        g = gcd_of(b, part);
        if (g == 0) return 0;
        nn = part / g;
        if (nn > MN_MAX) return 0;
        scr = s; m = b / g; n = nn;
        return 1;
    endfunction

    function automatic bit direct_crystal(input logic [31:0] b, input bit in_use,
                                          output logic [31:0] scr);
        scr = 0;
        for (int unsigned i = 0; i < entries_used(); i++) begin
            if (freq_tbl[i] == 0 || freq_tbl[i] % b != 0) continue;
            if (i == crystal_sel) begin
                scr = freq_tbl[i] / b;
                return 1;
            end
            if (!in_use || (mn_valid && mn_entry == i)) break;
        end
        return 0;
    endfunction

    function automatic int pick_shared_entry(input logic [31:0] b, output logic [31:0] scr,
                                             output logic [31:0] m, output logic [31:0] n);
        scr = 0; m = 0; n = 0;
        for (int unsigned i = 0; i < entries_used(); i++) begin
            if (freq_tbl[i] != 0 && freq_tbl[i] % b == 0) begin
                scr = freq_tbl[i] / b; m = 1; n = 1;
                return i;
            end
        end
        for (int unsigned i = 0; i < entries_used(); i++)
            if (solve_mn_div(freq_tbl[i], b, scr, m, n)) return i;
        return -1;
    endfunction

    // advances the predictor by one transfer and returns the expected result
    function automatic solve_t solve_bclk(input logic cmd, input logic [2:0] port,
                                          input logic [31:0] rate);
        solve_t r;
        bit in_use, ok;
        logic [31:0] s, mm, nn;
        int e;
        r = '0;
        r.status = 1'b1;
        r.kind = SRC_NONE;
        port_src[port] = SRC_NONE;
        if (cmd == CMD_RELEASE) begin
            r.status = 1'b0;
        end else if (rate != 0) begin
            in_use = 0;
            foreach (port_src[i]) if (port_src[i] == SRC_MN) in_use = 1;
            if (direct_crystal(rate, in_use, s)) begin
                port_src[port] = SRC_CRYSTAL;
                r.status = 1'b0; r.kind = SRC_CRYSTAL; r.scr = s; r.m = 1; r.n = 1;
            end else begin
                if (in_use) begin
                    ok = solve_mn_div(freq_tbl[mn_entry], rate, s, mm, nn);
                end else begin
                    e = pick_shared_entry(rate, s, mm, nn);
                    ok = (e >= 0);
                    if (ok) begin
                        mn_entry = e[1:0];
                        mn_valid = 1;
                        r.fresh = 1'b1;
                    end
                end
                if (ok) begin
                    port_src[port] = SRC_MN;
                    r.status = 1'b0; r.kind = SRC_MN; r.ecs = 1'b1;
                    r.scr = s; r.m = mm[23:0]; r.n = nn[23:0];
                end
            end
        end
        r.shared = mn_valid ? mn_entry : 2'd0;
        return r;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input word_t val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        if (idx <= REG_FREQ_3) freq_tbl[idx] = val;
        else if (idx == REG_COUNT) entry_count = val[2:0];
        else if (idx == REG_CRYSTAL) crystal_sel = val[2:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // the last item stays offered after its transfer, so withdraw it first
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic send_item(input logic cmd, input logic [2:0] port, input logic [31:0] rate,
                             input bit typed, input solve_t want);
        solve_t predicted;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'd0, rate, port};
        do @(posedge aclk); while (!s_tready);
        predicted = solve_bclk(cmd, port, rate);
        pending_q.push_back(typed ? want : predicted);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
    endtask

    // receiver side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        solve_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[86:0];
            if (pending_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected result transfer, expected none, got %h",
                         $time, got);
            end else begin
                want = pending_q.pop_front();
                check_field("status", want.status, got.status);
                check_field("source_kind", want.kind, got.kind);
                check_field("need_ecs", want.ecs, got.ecs);
                check_field("scr_divisor", want.scr, got.scr);
                check_field("m_value", want.m, got.m);
                check_field("n_value", want.n, got.n);
                check_field("new_source_selected", want.fresh, got.fresh);
                check_field("shared_source_entry", want.shared, got.shared);
            end
        end
    end

    function automatic void add_item(input logic cmd, input logic [2:0] port,
                                     input logic [31:0] rate, input bit typed = 0,
                                     input solve_t want = '0);
        row_t r;
        r.is_cfg = 0; r.idx = '0; r.val = '0;
        r.cmd = cmd; r.port = port; r.rate = rate; r.typed = typed; r.want = want;
        rows.push_back(r);
    endfunction

    function automatic void add_cfg(input logic [2:0] idx, input word_t val);
        row_t r;
        r = '{default: '0};
        r.is_cfg = 1; r.idx = idx; r.val = val;
        rows.push_back(r);
    endfunction

    function automatic logic [31:0] pick_rate();
        logic [31:0] fs [10] = '{8000, 11025, 16000, 22050, 32000, 44100, 48000,
                                 88200, 96000, 192000};
        logic [31:0] width [5] = '{1, 16, 24, 32, 64};
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 0;
            2: return $urandom_range(1, 1000);
            default: return fs[$urandom_range(0, 9)] * width[$urandom_range(0, 4)]
                            * $urandom_range(1, 2);
        endcase
    endfunction

    function automatic word_t pick_freq();
        case ($urandom_range(0, 5))
            0: return $urandom & 32'hffff_fffe;
            1: return 0;
            default: return $urandom_range(1, 2000) * 48000;
        endcase
    endfunction

    task automatic load_defaults();
        write_reg(REG_FREQ_0, 32'd19200000);
        write_reg(REG_FREQ_1, 32'd24576000);
        write_reg(REG_FREQ_2, 32'd96000000);
        write_reg(REG_FREQ_3, 32'd0);
        write_reg(REG_COUNT, 32'd3);
        write_reg(REG_CRYSTAL, 32'd4);
    endtask

    initial begin
        freq_tbl = '{32'd19200000, 32'd24576000, 32'd96000000, 32'd0};
        entry_count = 3'd3;
        crystal_sel = 3'd4;
        foreach (port_src[i]) port_src[i] = SRC_NONE;
        mn_entry = '0;
        mn_valid = 0;

        // directed rows
        add_item(CMD_RELEASE, 3'd0, 32'd0, 1, '0);
        add_item(CMD_SET, 3'd1, 32'd0, 1, '{status: 1'b1, kind: SRC_NONE, default: '0});
        add_item(CMD_SET, 3'd2, 32'hffff_ffff, 1,
                 '{status: 1'b1, kind: SRC_NONE, default: '0});
        add_item(CMD_SET, 3'd3, 32'd48000, 1,
                 '{status: 1'b0, kind: SRC_MN, ecs: 1'b1, scr: 32'd400, m: 24'd1, n: 24'd1,
                   fresh: 1'b1, shared: 2'd0});
        add_item(CMD_SET, 3'd4, 32'd44100);
        add_item(CMD_SET, 3'd5, 32'd3072000);
        add_item(CMD_SET, 3'd6, 32'd1);
        add_item(CMD_SET, 3'd7, 32'h8000_0001);
        for (int p = 3; p < 8; p++) add_item(CMD_RELEASE, p[2:0], 32'd0);
        add_cfg(REG_CRYSTAL, 32'd1);
        add_item(CMD_SET, 3'd0, 32'd3072000, 1,
                 '{status: 1'b0, kind: SRC_CRYSTAL, ecs: 1'b0, scr: 32'd8, m: 24'd1,
                   n: 24'd1, fresh: 1'b0, shared: 2'd0});
        add_cfg(REG_FREQ_3, 32'd12288000);
        add_cfg(REG_COUNT, 32'd7);
        add_cfg(REG_FREQ_0, 32'd0);
        add_item(CMD_SET, 3'd1, 32'd1536000);
        add_item(CMD_RELEASE, 3'd0, 32'd0);
        add_item(CMD_RELEASE, 3'd1, 32'd0);
        add_cfg(REG_COUNT, 32'd0);
        add_item(CMD_SET, 3'd2, 32'd48000, 1, '{status: 1'b1, kind: SRC_NONE, default: '0});
        add_cfg(REG_FREQ_2, 32'd44100001);   // odd entry
        add_cfg(REG_COUNT, 32'd3);
        add_cfg(REG_CRYSTAL, 32'd7);
        add_item(CMD_SET, 3'd3, 32'd44100);
        add_item(CMD_RELEASE, 3'd3, 32'd0);
        add_cfg(REG_FREQ_1, 32'hffff_ffff);
        add_item(CMD_SET, 3'd4, 32'h7fff_ffff);
        add_item(CMD_RELEASE, 3'd4, 32'd0);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                wait_drained();
                write_reg(rows[i].idx, rows[i].val);
            end else begin
                send_item(rows[i].cmd, rows[i].port, rows[i].rate, rows[i].typed,
                          rows[i].want);
            end
        end

        for (int ph = 0; ph < 7; ph++) begin
            wait_drained();
            if (ph == 6) begin
                quiet = 1;
                load_defaults();
            end else begin
                for (int k = 0; k < 4; k++) write_reg(k[2:0], pick_freq());
                write_reg(REG_COUNT, $urandom_range(0, 7));
                write_reg(REG_CRYSTAL, $urandom_range(0, 7));
            end
            if (ph == 2) hold_req = 1;   // results back up, input stalls
            for (int k = 0; k < 13; k++) begin
                if (ph == 4 && k == 6) wait_drained();
                send_item(($urandom_range(0, 3) == 0) ? CMD_RELEASE : CMD_SET,
                          $urandom_range(0, 7), pick_rate(), 0, '0);
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
